/* sv/nvg_pkg.sv */
package nvg_pkg;

	localparam int IDX_W = 7;
	localparam int DEG_W = 6;
	localparam int SMP_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OVF
	} nvg_state_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    start_series;
	} smp_t;

	typedef struct packed {
		logic [IDX_W-1:0] source_index;
		logic [IDX_W-1:0] target_index;
		logic [DEG_W-1:0] source_out_degree;
		logic [DEG_W-1:0] target_in_degree;
		logic             last_of_run;
		logic             overflow;
	} lnk_t;

endpackage

/* sv/nvg_cell.sv */
module nvg_cell #(
	parameter int SW = 16,
	parameter int RW = 6,
	parameter int DW = 6
) (
	input  logic                clk,
	input  logic                shift,
	input  logic signed [SW-1:0] d_smp,
	input  logic signed [SW:0]   d_rise,
	input  logic [RW-1:0]        d_run,
	input  logic [DW-1:0]        d_deg,
	output logic signed [SW-1:0] q_smp,
	output logic signed [SW:0]   q_rise,
	output logic [RW-1:0]        q_run,
	output logic [DW-1:0]        q_deg
);

	logic signed [SW-1:0] smp_q;
	logic signed [SW:0]   rise_q;
	logic [RW-1:0]        run_q;
	logic [DW-1:0]        deg_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			smp_q  <= d_smp;
			rise_q <= d_rise;
			run_q  <= d_run;
			deg_q  <= d_deg;
		end
	end

	assign q_smp  = smp_q;
	assign q_rise = rise_q;
	assign q_run  = run_q;
	assign q_deg  = deg_q;

endmodule

/* sv/nvg_vis.sv */
module nvg_vis #(
	parameter int SW = 16,
	parameter int RW = 6,
	parameter int DW = 6
) (
	input  logic signed [SW-1:0] h,
	input  logic [RW-1:0]        i,
	input  logic [RW-1:0]        k,
	input  logic signed [SW-1:0] c_smp,
	input  logic signed [SW:0]   c_rise,
	input  logic [RW-1:0]        c_run,
	input  logic [DW-1:0]        c_deg,
	output logic                 sees,
	output logic                 last,
	output logic signed [SW-1:0] n_smp,
	output logic signed [SW:0]   n_rise,
	output logic [RW-1:0]        n_run,
	output logic [DW-1:0]        n_deg
);

	localparam int PW = SW + RW + 2;

	logic signed [SW:0]   rise;
	logic [RW-1:0]        run;
	logic signed [PW-1:0] prod_best;
	logic signed [PW-1:0] prod_new;
	logic [RW:0]          i_nx;
	logic                 earlier;

	assign rise      = (SW+1)'(h) - (SW+1)'(c_smp);
	assign run       = k - i;
	assign prod_best = PW'(c_rise) * PW'($signed({1'b0, run}));
	assign prod_new  = PW'(rise) * PW'($signed({1'b0, c_run}));
	assign i_nx      = (RW+1)'(i) + (RW+1)'(1);
	assign earlier   = i < k;
	assign last      = i_nx == {1'b0, k};
	assign sees      = earlier && (last || (prod_best < prod_new));

	always_comb begin
		n_smp  = c_smp;
		n_rise = c_rise;
		n_run  = c_run;
		n_deg  = c_deg;
		if (sees) begin
			n_rise = rise;
			n_run  = run;
			n_deg  = c_deg + DW'(1);
		end else if (i == k) begin
			n_smp = h;
			n_deg = '0;
		end
	end

endmodule

/* sv/natural_visibility_graph_unit.sv */
// Natural visibility graph builder.
// Input channel smp (valid/ready) carries one sample and a start flag. Each
// accepted sample becomes the next node of the series; start_series first
// empties the stored series so the sample becomes node 1.
// Output channel lnk (valid/ready) carries one transfer per edge i -> k, in
// ascending source order, with both degrees; the final one has last_of_run.
// A sample arriving with MAX_SAMPLES nodes stored and no start gives a single
// overflow transfer and is dropped. Node 1 of a series gives no transfer.
// Node state sits in a ring of MAX_SAMPLES cells that rotates once per
// sample past a single slope-compare unit; smp_ready is high only between
// rotations. A stalled receiver freezes the ring; the output register holds
// a result while the next sample is taken in. Reset empties the series and
// the output register; the cells themselves are not cleared and need no
// clearing pass.
module natural_visibility_graph_unit #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          smp_valid,
	output logic          smp_ready,
	input  nvg_pkg::smp_t smp,
	output logic          lnk_valid,
	input  logic          lnk_ready,
	output nvg_pkg::lnk_t lnk
);

	import nvg_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = $clog2(MAX_SAMPLES);
	localparam int SW = SAMPLE_BITS;

	nvg_state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        i_q;
	logic [IW-1:0]        kin_q;
	logic signed [SW-1:0] h_q;
	logic                 lnk_valid_q;
	lnk_t                 lnk_q;

	logic signed [SW-1:0] c_smp  [MAX_SAMPLES];
	logic signed [SW:0]   c_rise [MAX_SAMPLES];
	logic [IW-1:0]        c_run  [MAX_SAMPLES];
	logic [IW-1:0]        c_deg  [MAX_SAMPLES];

	logic signed [SW-1:0] n_smp;
	logic signed [SW:0]   n_rise;
	logic [IW-1:0]        n_run;
	logic [IW-1:0]        n_deg;
	logic                 sees;
	logic                 last;

	logic                 accept;
	logic                 fits;
	logic                 free;
	logic                 adv;
	logic                 ovf_load;
	logic [IW-1:0]        k_new;
	logic [SW-1:0]        raw;

	assign accept = smp_valid && smp_ready;
	assign fits   = smp.start_series || (count_q < CW'(MAX_SAMPLES));
	assign free   = !lnk_valid_q || lnk_ready;
	assign k_new  = smp.start_series ? '0 : count_q[IW-1:0];
	assign raw    = SW'($unsigned(smp.sample));

	always_comb begin
		state_d   = state_q;
		smp_ready = 1'b0;
		adv       = 1'b0;
		ovf_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				smp_ready = 1'b1;
				if (smp_valid) begin
					state_d = fits ? ST_RUN : ST_OVF;
				end
			end
			ST_RUN: begin
				adv = free;
				if (free && (i_q == IW'(MAX_SAMPLES - 1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_OVF: begin
				ovf_load = free;
				if (free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			lnk_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && fits) begin
				count_q <= CW'(k_new) + CW'(1);
			end
			if ((adv && sees) || ovf_load) begin
				lnk_valid_q <= 1'b1;
			end else if (lnk_ready) begin
				lnk_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k_q   <= k_new;
			i_q   <= '0;
			kin_q <= '0;
			h_q   <= $signed(raw);
		end
		if (adv) begin
			i_q <= i_q + IW'(1);
			if (sees) begin
				kin_q <= kin_q + IW'(1);
				lnk_q.source_index      <= IDX_W'(i_q) + IDX_W'(1);
				lnk_q.target_index      <= IDX_W'(k_q) + IDX_W'(1);
				lnk_q.source_out_degree <= DEG_W'(n_deg);
				lnk_q.target_in_degree  <= DEG_W'(kin_q) + DEG_W'(1);
				lnk_q.last_of_run       <= last;
				lnk_q.overflow          <= 1'b0;
			end
		end
		if (ovf_load) begin
			lnk_q.source_index      <= '0;
			lnk_q.target_index      <= '0;
			lnk_q.source_out_degree <= '0;
			lnk_q.target_in_degree  <= '0;
			lnk_q.last_of_run       <= 1'b1;
			lnk_q.overflow          <= 1'b1;
		end
	end

	nvg_vis #(
		.SW(SW),
		.RW(IW),
		.DW(IW)
	) u_vis (
		.h      (h_q),
		.i      (i_q),
		.k      (k_q),
		.c_smp  (c_smp[0]),
		.c_rise (c_rise[0]),
		.c_run  (c_run[0]),
		.c_deg  (c_deg[0]),
		.sees   (sees),
		.last   (last),
		.n_smp  (n_smp),
		.n_rise (n_rise),
		.n_run  (n_run),
		.n_deg  (n_deg)
	);

	for (genvar j = 0; j < MAX_SAMPLES; j++) begin : g_ring
		if (j == MAX_SAMPLES - 1) begin : g_tail
			nvg_cell #(
				.SW(SW),
				.RW(IW),
				.DW(IW)
			) u_cell (
				.clk    (clk),
				.shift  (adv),
				.d_smp  (n_smp),
				.d_rise (n_rise),
				.d_run  (n_run),
				.d_deg  (n_deg),
				.q_smp  (c_smp[j]),
				.q_rise (c_rise[j]),
				.q_run  (c_run[j]),
				.q_deg  (c_deg[j])
			);
		end else begin : g_body
			nvg_cell #(
				.SW(SW),
				.RW(IW),
				.DW(IW)
			) u_cell (
				.clk    (clk),
				.shift  (adv),
				.d_smp  (c_smp[j+1]),
				.d_rise (c_rise[j+1]),
				.d_run  (c_run[j+1]),
				.d_deg  (c_deg[j+1]),
				.q_smp  (c_smp[j]),
				.q_rise (c_rise[j]),
				.q_run  (c_run[j]),
				.q_deg  (c_deg[j])
			);
		end
	end

	assign lnk_valid = lnk_valid_q;
	assign lnk       = lnk_q;

endmodule

/* sv/nvg_chk.sv */
module nvg_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          smp_valid,
	input logic          smp_ready,
	input nvg_pkg::smp_t smp,
	input logic          lnk_valid,
	input logic          lnk_ready,
	input nvg_pkg::lnk_t lnk
);

	import nvg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		lnk_valid && !lnk_ready |=> lnk_valid && $stable(lnk))
		else $error("result changed while stalled");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		lnk_valid && lnk.overflow |-> lnk.last_of_run && lnk.source_index == '0
			&& lnk.target_index == '0 && lnk.target_in_degree == '0)
		else $error("malformed overflow result");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		lnk_valid && !lnk.overflow |-> lnk.source_index != '0
			&& lnk.source_index < lnk.target_index)
		else $error("source does not precede target");

	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		lnk_valid && !lnk.overflow |-> lnk.source_out_degree != '0
			&& lnk.target_in_degree != '0
			&& lnk.target_in_degree <= lnk.source_index)
		else $error("degree out of range");

	a_neigh: assert property (@(posedge clk) disable iff (!arst_n)
		lnk_valid && !lnk.overflow && lnk.last_of_run
			|-> lnk.source_index + 7'd1 == lnk.target_index)
		else $error("final edge is not from the direct neighbour");

endmodule

bind natural_visibility_graph_unit nvg_chk u_nvg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp_valid),
	.smp_ready (smp_ready),
	.smp       (smp),
	.lnk_valid (lnk_valid),
	.lnk_ready (lnk_ready),
	.lnk       (lnk)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	import nvg_pkg::*;

	localparam int SERIES_CAP = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_ITEMS = 75;

	typedef enum logic [1:0] {
		BY_MODEL,
		NO_EDGE,
		ONE_EDGE
	} row_kind_t;

	typedef enum logic [2:0] {
		SH_WIDE,
		SH_NARROW,
		SH_CONVEX,
		SH_CONCAVE,
		SH_RAILS,
		SH_WALK
	} shape_t;

	typedef struct packed {
		smp_t      item;
		row_kind_t kind;
		lnk_t      exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic smp_valid = 1'b0;
	logic smp_ready;
	smp_t smp = '0;
	logic lnk_valid;
	logic lnk_ready = 1'b0;
	lnk_t lnk;

	natural_visibility_graph_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp       (smp),
		.lnk_valid (lnk_valid),
		.lnk_ready (lnk_ready),
		.lnk       (lnk)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	int idle_pct = 0;
	int stall_pct = 0;
	int samples_offered = 0;
	int miss_count = 0;
	int quiet_cycles = 0;

	longint series_val [SERIES_CAP];
	longint slope_rise [SERIES_CAP];
	int     slope_run [SERIES_CAP];
	int     fan_out [SERIES_CAP];
	int     node_count = 0;

	lnk_t links_due [$];
	row_t samples_in_flight [$];
	row_t landed;

	row_t opening_rows [0:19];

	function automatic string link_text(input lnk_t l);
		return $sformatf("src %0d tgt %0d out %0d in %0d last %0b ovf %0b",
			l.source_index, l.target_index, l.source_out_degree,
			l.target_in_degree, l.last_of_run, l.overflow);
	endfunction

	function automatic void grow_graph(input row_t r);
		lnk_t   fresh [$];
		lnk_t   e;
		longint rise;
		int     k;
		int     run;
		int     kin;
		bit     sees;
		kin = 0;
		if (r.item.start_series) begin
			foreach (fan_out[i]) fan_out[i] = 0;
			node_count = 0;
		end
		if (node_count >= SERIES_CAP) begin
			e = '0;
			e.last_of_run = 1'b1;
			e.overflow = 1'b1;
			fresh.push_back(e);
		end else begin
			k = node_count;
			series_val[k] = longint'(r.item.sample);
			fan_out[k] = 0;
			node_count = k + 1;
			for (int i = 0; i < k; i++) begin
				rise = longint'(r.item.sample) - series_val[i];
				run = k - i;
				if (i + 1 == k)
					sees = 1'b1;
				else
					sees = slope_rise[i] * run < rise * slope_run[i];
				if (sees) begin
					slope_rise[i] = rise;
					slope_run[i] = run;
					fan_out[i] = (fan_out[i] + 1) & 6'h3F;
					kin++;
					e = '0;
					e.source_index = IDX_W'(i + 1);
					e.target_index = IDX_W'(k + 1);
					e.source_out_degree = DEG_W'(fan_out[i]);
					e.target_in_degree = DEG_W'(kin);
					fresh.push_back(e);
				end
			end
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last_of_run = 1'b1;
		end
		case (r.kind)
			BY_MODEL: foreach (fresh[i]) links_due.push_back(fresh[i]);
			ONE_EDGE: links_due.push_back(r.exp);
			default: ;
		endcase
	endfunction

	function automatic void check_link(input lnk_t got);
		lnk_t want;
		if (links_due.size() == 0) begin
			miss_count++;
			if (miss_count <= 10)
				$display("unexpected transfer: got %s", link_text(got));
			return;
		end
		want = links_due.pop_front();
		if (got.source_index !== want.source_index ||
				got.target_index !== want.target_index ||
				got.source_out_degree !== want.source_out_degree ||
				got.target_in_degree !== want.target_in_degree ||
				got.last_of_run !== want.last_of_run ||
				got.overflow !== want.overflow) begin
			miss_count++;
			if (miss_count <= 10)
				$display("mismatch: expected %s, got %s", link_text(want), link_text(got));
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (lnk_valid && lnk_ready)
				check_link(lnk);
			if (smp_valid && smp_ready) begin
				landed = samples_in_flight.pop_front();
				grow_graph(landed);
			end
		end
	end

	always @(posedge clk) begin
		lnk_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_valid && smp_ready) || (lnk_valid && lnk_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles == QUIET_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	task automatic offer(input row_t r);
		if ($urandom_range(99) < idle_pct) begin
			smp_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		smp <= r.item;
		smp_valid <= 1'b1;
		samples_in_flight.push_back(r);
		samples_offered++;
		do @(posedge clk); while (!smp_ready);
	endtask

	task automatic settle();
		smp_valid <= 1'b0;
		@(posedge clk);
		while (links_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SMP_W-1:0] shape_value(input shape_t sh, input int j,
			input logic signed [SMP_W-1:0] prev);
		int v;
		case (sh)
			SH_NARROW: v = int'($urandom_range(6)) - 3;
			SH_CONVEX: v = 7 * j * j - 16384;
			SH_CONCAVE: v = 16383 - 7 * j * j;
			SH_RAILS: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			SH_WALK: begin
				v = int'(prev) + int'($urandom_range(200)) - 100;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
			end
			default: v = int'($urandom);
		endcase
		return SMP_W'(v);
	endfunction

	task automatic send_series(input int len, input shape_t sh, input bit fresh_start);
		row_t r;
		logic signed [SMP_W-1:0] prev;
		prev = '0;
		for (int j = 0; j < len; j++) begin
			r = '0;
			r.item.sample = shape_value(sh, j, prev);
			r.item.start_series = (j == 0) && fresh_start;
			r.kind = BY_MODEL;
			prev = r.item.sample;
			offer(r);
		end
	endtask

	int idle_mix [4] = '{0, 54, 0, 11};
	int stall_mix [4] = '{0, 0, 54, 11};

	initial begin
		int quota;
		int len;
		opening_rows = '{
			'{'{16'sh0000, 1'b0}, NO_EDGE, lnk_t'('0)},
			'{'{16'sh7FFF, 1'b0}, ONE_EDGE, '{7'd1, 7'd2, 6'd1, 6'd1, 1'b1, 1'b0}},
			'{'{16'sh8000, 1'b0}, ONE_EDGE, '{7'd2, 7'd3, 6'd1, 6'd1, 1'b1, 1'b0}},
			'{'{16'sh7FFF, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh8000, 1'b1}, NO_EDGE, lnk_t'('0)},
			'{'{16'sh8000, 1'b0}, ONE_EDGE, '{7'd1, 7'd2, 6'd1, 6'd1, 1'b1, 1'b0}},
			'{'{16'sh8000, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh8001, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh0000, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh7FFF, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh0064, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'shFFFB, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh7FFF, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh5555, 1'b1}, NO_EDGE, lnk_t'('0)},
			'{'{16'shAAAA, 1'b0}, ONE_EDGE, '{7'd1, 7'd2, 6'd1, 6'd1, 1'b1, 1'b0}},
			'{'{16'shFFFF, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh0001, 1'b0}, BY_MODEL, lnk_t'('0)},
			'{'{16'sh0001, 1'b1}, NO_EDGE, lnk_t'('0)},
			'{'{16'sh0002, 1'b0}, ONE_EDGE, '{7'd1, 7'd2, 6'd1, 6'd1, 1'b1, 1'b0}},
			'{'{16'sh0003, 1'b0}, BY_MODEL, lnk_t'('0)}
		};
		foreach (series_val[i]) begin
			series_val[i] = 0;
			slope_rise[i] = 0;
			slope_run[i] = 0;
			fan_out[i] = 0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) offer(opening_rows[i]);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_mix[ph];
			stall_pct = stall_mix[ph];
			quota = samples_offered + PHASE_ITEMS;
			if (ph == 0)
				send_series(66, SH_CONVEX, 1'b1);
			if (ph == 2)
				send_series(65, shape_t'($urandom_range(5)), 1'b1);
			while (samples_offered < quota) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(40, 30);
				else
					len = $urandom_range(14, 2);
				send_series(len, shape_t'($urandom_range(5)), $urandom_range(9) != 0);
			end
			settle();
		end

		if (miss_count == 0 && links_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
